FILE: hdl/u8d_pkg.sv
// u8d_pkg: shared types and constants for the UTF-8 decoder.
// Byte class codes, queue sizing and the queue entry type.
// No dependencies.
package u8d_pkg;

  // Byte class codes, set by the front end
  localparam logic [2:0] CLS_ASCII = 3'd0;
  localparam logic [2:0] CLS_LEAD2 = 3'd1;
  localparam logic [2:0] CLS_LEAD3 = 3'd2;
  localparam logic [2:0] CLS_LEAD4 = 3'd3;
  localparam logic [2:0] CLS_CONT  = 3'd4;
  localparam logic [2:0] CLS_SKIP  = 3'd5;

  // Queue between front and back; depth must be a power of two
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam int CP_W = 21;

  // One classified byte: class, payload bits already masked, end flag
  typedef struct packed {
    logic [2:0] cls;
    logic [6:0] bits;
    logic       last;
  } u8d_item_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } u8d_q_status_t;

endpackage

FILE: hdl/utf8_to_codepoint_decoder_top.sv
// utf8_to_codepoint_decoder_top: UTF-8 byte stream to code point decoder.
// Depends on u8d_pkg, u8d_front, u8d_fifo, u8d_back.
//
// Usage:
//   Input channel (in_valid / in_stall): one byte per transaction, with
//   in_last_byte set on the final byte of a string.
//   Output channel (out_valid / out_stall): one result per completed code
//   point; a final byte always gives one result (out_end_of_string = 1),
//   with out_has_code_point = 0 if nothing completed on it.
//   Throughput: one byte per cycle while out_stall is low; the sequence
//   state is updated in the back end as each byte is popped.
//   Path: an accepted byte is written to the queue, decoded at the queue
//   head and its result captured in the output register; bytes already
//   queued ahead of it are handled first.
//   Stall: while out_stall is high and a result is held, the output
//   register holds and the back end stops; the front keeps taking bytes
//   until the 4-entry queue fills, then raises in_stall.
//   Reset (rst_n low, synchronous): queue emptied, no sequence pending,
//   no result shown.
module utf8_to_codepoint_decoder_top import u8d_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte_in,
  input  logic            in_last_byte,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CP_W-1:0] out_code_point,
  output logic            out_has_code_point,
  output logic            out_end_of_string
);

  u8d_q_status_t q_status;
  u8d_item_t     push_item, head_item;
  logic          push, pop;

  // Front end: handshake and classification
  u8d_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte_in   (in_byte_in),
    .in_last_byte (in_last_byte),
    .q_status     (q_status),
    .push         (push),
    .push_item    (push_item)
  );

  // Decoupling queue
  u8d_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_status  (q_status)
  );

  // Back end: sequence assembly and output
  u8d_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_status           (q_status),
    .head_item          (head_item),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_code_point     (out_code_point),
    .out_has_code_point (out_has_code_point),
    .out_end_of_string  (out_end_of_string)
  );

endmodule

FILE: hdl/u8d_front.sv
// u8d_front: input handshake and byte classification.
// Depends on u8d_pkg.
module u8d_front import u8d_pkg::*; (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte_in,
  input  logic          in_last_byte,
  input  u8d_q_status_t q_status,
  output logic          push,
  output u8d_item_t     push_item
);

  // Stall whenever the queue cannot take the transaction
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  // Classify lead / continuation and strip the marker bits
  always_comb begin
    push_item.last = in_last_byte;
    push_item.bits = 7'd0;
    unique case (in_byte_in) inside
      [8'h00:8'h7F]: begin
        push_item.cls  = CLS_ASCII;
        push_item.bits = in_byte_in[6:0];
      end
      [8'h80:8'hBF]: begin
        push_item.cls  = CLS_CONT;
        push_item.bits = {1'b0, in_byte_in[5:0]};
      end
      [8'hC0:8'hDF]: begin
        push_item.cls  = CLS_LEAD2;
        push_item.bits = {2'b00, in_byte_in[4:0]};
      end
      [8'hE0:8'hEF]: begin
        push_item.cls  = CLS_LEAD3;
        push_item.bits = {3'b000, in_byte_in[3:0]};
      end
      [8'hF0:8'hF7]: begin
        push_item.cls  = CLS_LEAD4;
        push_item.bits = {4'b0000, in_byte_in[2:0]};
      end
      default: begin
        push_item.cls = CLS_SKIP;   // invalid lead 0xF8-0xFF
      end
    endcase
  end

endmodule

FILE: hdl/u8d_fifo.sv
// u8d_fifo: short queue of classified bytes between front and back.
// Depends on u8d_pkg.
module u8d_fifo import u8d_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  u8d_item_t     push_item,
  input  logic          pop,
  output u8d_item_t     head_item,
  output u8d_q_status_t q_status
);

  u8d_item_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r, count_nxt;

  assign q_status.full  = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign q_status.empty = (count_r == '0);
  assign head_item      = mem_r[rd_ptr_r];

  // Occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

FILE: hdl/u8d_back.sv
// u8d_back: sequence state, code point assembly and output register.
// Depends on u8d_pkg.
module u8d_back import u8d_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  u8d_q_status_t   q_status,
  input  u8d_item_t       head_item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CP_W-1:0] out_code_point,
  output logic            out_has_code_point,
  output logic            out_end_of_string
);

  logic [CP_W-1:0] acc_r, acc_nxt;
  logic [1:0]      rem_r, rem_nxt;
  logic            valid_r;
  logic [CP_W-1:0] cp_r;
  logic            has_r, eos_r;
  logic            done;
  logic [CP_W-1:0] cp;
  logic            emit;

  // Take the next queued byte when the output slot is free or draining
  assign pop  = !q_status.empty && (!valid_r || !out_stall);
  assign emit = pop && (done || head_item.last);

  // Decode step for the head byte
  always_comb begin
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    done    = 1'b0;
    cp      = '0;
    if (rem_r != 2'd0 && head_item.cls == CLS_CONT) begin
      acc_nxt = {acc_r[CP_W-7:0], head_item.bits[5:0]};
      rem_nxt = rem_r - 2'd1;
      if (rem_r == 2'd1) begin
        done = 1'b1;
        cp   = acc_nxt;
      end
    end else begin
      rem_nxt = 2'd0;
      unique case (head_item.cls)
        CLS_ASCII: begin
          done = 1'b1;
          cp   = CP_W'(head_item.bits);
        end
        CLS_LEAD2: begin
          acc_nxt = CP_W'(head_item.bits);
          rem_nxt = 2'd1;
        end
        CLS_LEAD3: begin
          acc_nxt = CP_W'(head_item.bits);
          rem_nxt = 2'd2;
        end
        CLS_LEAD4: begin
          acc_nxt = CP_W'(head_item.bits);
          rem_nxt = 2'd3;
        end
        default: ;  // stray continuation or invalid lead
      endcase
    end
    // End of string returns to the idle state
    if (head_item.last) begin
      acc_nxt = '0;
      rem_nxt = 2'd0;
    end
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      rem_r <= 2'd0;
    end else if (pop) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (emit) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cp_r  <= cp;
      has_r <= done;
      eos_r <= head_item.last;
    end
  end

  assign out_valid          = valid_r;
  assign out_code_point     = cp_r;
  assign out_has_code_point = has_r;
  assign out_end_of_string  = eos_r;

  // A popped end byte always leaves the decoder idle
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head_item.last |=> rem_r == 2'd0 && acc_r == '0)
    else $error("state not cleared after end of string");

  // An empty result only comes from the end byte
  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !has_r |-> eos_r && cp_r == '0)
    else $error("result without code point is not an end marker");

  // Never pop from an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.empty |-> !pop)
    else $error("pop from empty queue");

  // A pending result is never overwritten while stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_stall |-> !pop)
    else $error("output register overwritten during stall");

endmodule

FILE: tb/sv/tb_utf8_to_codepoint_decoder_top.sv
// Self-checking testbench for utf8_to_codepoint_decoder_top.
// Drives byte strings through the valid/stall channels, predicts each code point
// in a local decoder model and checks every result; depends on u8d_pkg and the top.
`timescale 1ns / 1ps

module tb_utf8_to_codepoint_decoder_top import u8d_pkg::*;;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int TAIL_CYCLES  = 16;

  // Receiver stall patterns
  localparam logic [1:0] STALL_NONE   = 2'd0;
  localparam logic [1:0] STALL_LIGHT  = 2'd1;
  localparam logic [1:0] STALL_HEAVY  = 2'd2;
  localparam logic [1:0] STALL_TOGGLE = 2'd3;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } utf8_byte_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            has_cp;
    logic            eos;
  } cp_result_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [7:0]      in_byte_in = 8'd0;
  logic            in_last_byte = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [CP_W-1:0] out_code_point;
  logic            out_has_code_point;
  logic            out_end_of_string;

  utf8_byte_t byte_q[$];
  cp_result_t expected_cp_q[$];

  // Decoder model state
  logic [CP_W-1:0] cp_accum = '0;
  logic [1:0]      cont_left = 2'd0;

  int         mismatch_count = 0;
  int         idle_cycles = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         mode_cycles = 0;
  int         run_cycles = 0;
  logic [1:0] stall_mode = STALL_NONE;
  logic       stall_pat;
  logic       long_hold = 1'b0;
  logic       tail_flush = 1'b0;
  utf8_byte_t next_byte;
  cp_result_t predicted;
  cp_result_t expected;

  utf8_to_codepoint_decoder_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte_in         (in_byte_in),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_code_point     (out_code_point),
    .out_has_code_point (out_has_code_point),
    .out_end_of_string  (out_end_of_string)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic [2:0] byte_class(input logic [7:0] b);
    if (!b[7]) return CLS_ASCII;
    if (b[7:6] == 2'b10) return CLS_CONT;
    if (b[7:5] == 3'b110) return CLS_LEAD2;
    if (b[7:4] == 4'b1110) return CLS_LEAD3;
    if (b[7:3] == 5'b11110) return CLS_LEAD4;
    return CLS_SKIP;
  endfunction

  // Advance the decoder model by one byte; returns 1 when a result is due
  function automatic bit predict_code_point(input logic [7:0] b, input logic lst,
                                            output cp_result_t res);
    logic [2:0] cls;
    bit         done;
    cls  = byte_class(b);
    done = 1'b0;
    res  = '0;
    if (cont_left != 2'd0 && cls == CLS_CONT) begin
      cp_accum  = {cp_accum[CP_W-7:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        res.code_point = cp_accum;
        done = 1'b1;
      end
    end else begin
      // a non-continuation drops any pending lead and starts over
      cont_left = 2'd0;
      case (cls)
        CLS_ASCII: begin
          res.code_point = {{(CP_W-7){1'b0}}, b[6:0]};
          done = 1'b1;
        end
        CLS_LEAD2: begin
          cp_accum  = {{(CP_W-5){1'b0}}, b[4:0]};
          cont_left = 2'd1;
        end
        CLS_LEAD3: begin
          cp_accum  = {{(CP_W-4){1'b0}}, b[3:0]};
          cont_left = 2'd2;
        end
        CLS_LEAD4: begin
          cp_accum  = {{(CP_W-3){1'b0}}, b[2:0]};
          cont_left = 2'd3;
        end
        default: ; // stray continuation or invalid lead
      endcase
    end
    if (lst) begin
      cp_accum  = '0;
      cont_left = 2'd0;
    end
    res.has_cp = done;
    res.eos    = lst;
    return done || lst;
  endfunction

  // Random byte of a given class
  function automatic logic [7:0] random_byte(input logic [2:0] cls);
    logic [7:0] r;
    r = 8'($urandom);
    case (cls)
      CLS_ASCII: return {1'b0, r[6:0]};
      CLS_LEAD2: return {3'b110, r[4:0]};
      CLS_LEAD3: return {4'b1110, r[3:0]};
      CLS_LEAD4: return {5'b11110, r[2:0]};
      CLS_CONT:  return {2'b10, r[5:0]};
      default:   return {5'b11111, r[2:0]};
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic lst);
    utf8_byte_t t;
    t.value = b;
    t.last  = lst;
    byte_q = {byte_q, t};
  endtask

  // One string: mostly well-formed sequences, some noise and truncated leads
  task automatic push_string(input int n_tokens);
    logic [7:0] s[$];
    logic [2:0] cls;
    int         n_cont;
    int         pick;
    for (int t = 0; t < n_tokens; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        cls    = 3'($urandom_range(CLS_ASCII, CLS_LEAD4));
        n_cont = int'(cls);
      end else if (pick < 92) begin
        cls    = 3'($urandom_range(CLS_LEAD2, CLS_LEAD4));
        n_cont = $urandom_range(0, int'(cls) - 1);
      end else if (pick < 96) begin
        cls    = CLS_CONT;
        n_cont = $urandom_range(0, 2);
      end else begin
        cls    = CLS_SKIP;
        n_cont = $urandom_range(0, 1);
      end
      s = {s, random_byte(cls)};
      for (int k = 0; k < n_cont; k++) s = {s, random_byte(CLS_CONT)};
    end
    foreach (s[i]) push_byte(s[i], i == s.size() - 1);
  endtask

  // Stimulus, reset and end of run
  initial begin
    // directed: field extremes and each special case
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hDF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hEF, 1'b0); push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hF0, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0);
    // max 21-bit value, ending the string on the completing byte
    push_byte(8'hF7, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b1);
    // stray continuations and invalid leads
    push_byte(8'h80, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hF8, 1'b0); push_byte(8'hFF, 1'b0);
    // interrupted sequence resyncs on the next plain byte
    push_byte(8'hC3, 1'b0); push_byte(8'h41, 1'b0);
    // truncated at end of string
    push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b1);
    // end on a skipped byte, then on a plain byte
    push_byte(8'hFF, 1'b1);
    push_byte(8'h41, 1'b1);

    while (byte_q.size() < RANDOM_ITEMS + 25) push_string($urandom_range(1, 12));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (byte_q.size() != 0 || in_valid || expected_cp_q.size() != 0) @(posedge clk);
    tail_flush <= 1'b1;
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_cp_q.size() == 0) begin
      $display("tb_utf8_to_codepoint_decoder_top: PASS");
    end else begin
      $display("tb_utf8_to_codepoint_decoder_top: FAIL");
    end
    $finish;
  end

  // Driver: bursts of bytes with random gaps, payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0 || byte_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        next_byte = byte_q.pop_front();
        in_valid     <= 1'b1;
        in_byte_in   <= next_byte.value;
        in_last_byte <= next_byte.last;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 32);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Long receiver hold-offs so the internal queue fills and backs up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      run_cycles <= 0;
      long_hold  <= 1'b0;
    end else begin
      run_cycles <= run_cycles + 1;
      long_hold  <= (run_cycles >= 300 && run_cycles < 600) ||
                    (run_cycles >= 1500 && run_cycles < 1650);
    end
  end

  // Receiver stall pattern, with the mode picked anew at random intervals
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_cycles <= 0) begin
        stall_mode  = 2'($urandom_range(0, 3));
        mode_cycles = $urandom_range(20, 80);
      end
      mode_cycles--;
      case (stall_mode)
        STALL_NONE:  stall_pat = 1'b0;
        STALL_LIGHT: stall_pat = ($urandom_range(0, 3) == 0);
        STALL_HEAVY: stall_pat = ($urandom_range(0, 3) != 0);
        default:     stall_pat = ~out_stall;
      endcase
      out_stall <= !tail_flush && (long_hold || stall_pat);
    end
  end

  // Monitor: predict on each accepted byte, check each accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (predict_code_point(in_byte_in, in_last_byte, predicted))
          expected_cp_q = {expected_cp_q, predicted};
      end
      if (out_valid && !out_stall) begin
        if (expected_cp_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected transaction: cp=%h has=%b eos=%b", $time,
                   out_code_point, out_has_code_point, out_end_of_string);
        end else begin
          expected = expected_cp_q.pop_front();
          if (out_code_point !== expected.code_point) begin
            mismatch_count++;
            $display("%0t: code_point expected %h actual %h", $time,
                     expected.code_point, out_code_point);
          end
          if (out_has_code_point !== expected.has_cp) begin
            mismatch_count++;
            $display("%0t: has_code_point expected %b actual %b", $time,
                     expected.has_cp, out_has_code_point);
          end
          if (out_end_of_string !== expected.eos) begin
            mismatch_count++;
            $display("%0t: end_of_string expected %b actual %b", $time,
                     expected.eos, out_end_of_string);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_utf8_to_codepoint_decoder_top: FAIL");
        $finish;
      end
    end
  end

endmodule
